### design/bmf_pkg.sv
// Package of the box mean filter: item types and fixed constants.
// Used by bmf_div and box_mean_filter; depends on nothing.
package bmf_pkg;

	localparam int PIX_W = 8;
	localparam int FW_W = 11;
	localparam int FH_W = 13;
	localparam int K_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 3'd4;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_c0;
		logic [PIX_W-1:0] pixel_c1;
		logic [PIX_W-1:0] pixel_c2;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] mean_c0;
		logic [PIX_W-1:0] mean_c1;
		logic [PIX_W-1:0] mean_c2;
		logic frame_end;
	} mean_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

endpackage

### design/bmf_div.sv
// Three-lane restoring divider, one quotient bit per cycle per lane.
// Depends on bmf_pkg.
module bmf_div import bmf_pkg::*; #(
	parameter int NUM_W = 16,
	parameter int DEN_W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [NUM_W-1:0] num0,
	input  logic [NUM_W-1:0] num1,
	input  logic [NUM_W-1:0] num2,
	input  logic [DEN_W-1:0] den,
	output div_ctl_t ctl,
	output logic [PIX_W-1:0] quo0,
	output logic [PIX_W-1:0] quo1,
	output logic [PIX_W-1:0] quo2
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [NUM_W-1:0] q_q [3];
	logic [DEN_W:0] r_q [3];
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0] r_sh [3];
	logic [DEN_W:0] r_sub [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_sh[i] = {r_q[i][DEN_W-1:0], q_q[i][NUM_W-1]};
			r_sub[i] = r_sh[i] - {1'b0, den_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q[0] <= num0;
			q_q[1] <= num1;
			q_q[2] <= num2;
			for (int i = 0; i < 3; i++) r_q[i] <= '0;
			den_q <= den;
		end else if (busy_q) begin
			for (int i = 0; i < 3; i++) begin
				if (r_sh[i] >= {1'b0, den_q}) begin
					r_q[i] <= r_sub[i];
					q_q[i] <= {q_q[i][NUM_W-2:0], 1'b1};
				end else begin
					r_q[i] <= r_sh[i];
					q_q[i] <= {q_q[i][NUM_W-2:0], 1'b0};
				end
			end
		end
	end

	assign ctl.start = start;
	assign ctl.done = done_q;
	assign quo0 = q_q[0][PIX_W-1:0];
	assign quo1 = q_q[1][PIX_W-1:0];
	assign quo2 = q_q[2][PIX_W-1:0];
endmodule

### design/box_mean_filter.sv
// Top level of the box mean filter: line store, column-sum store and sequencer.
// Depends on bmf_pkg and bmf_div.
module box_mean_filter import bmf_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 4096,
	parameter int MAX_KERNEL = 15
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  pixel_t in_item,
	output logic out_valid,
	input  logic out_stall,
	output mean_t out_item
);
	// The block computes, for a raster-order stream of gray or RGB888 pixels, the truncated
	// mean over an odd kernel_width by kernel_height window, and emits one item for each
	// pixel that completes a full window, so only the valid region of the frame appears;
	// frame_end marks the last item of the frame. Items are handled one at a time. A pixel
	// that produces no result passes through the cycle in which it is taken, two single-port
	// reads of the column-sum memory and the window update; a pixel that produces one then
	// passes through the bit-serial division by the window area and its done flag and the
	// load of the output register, which waits while a stalled item still holds it.
	// The output register holds a finished item while the next pixel is already taken in.
	// With an even kernel, or one larger than the frame, pixels are taken one per cycle and
	// nothing is produced. Any write to a defined register restarts the frame. No clearing
	// pass follows reset: the stores are only read where written earlier in the same frame.

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int WE_W = $clog2(MAX_WIDTH + 1);
	localparam int HE_W = $clog2(MAX_HEIGHT + 1);
	localparam int RING_W = $clog2(MAX_KERNEL);
	localparam int LS_DEPTH = MAX_KERNEL * MAX_WIDTH;
	localparam int LA_W = $clog2(LS_DEPTH);
	localparam int CS_W = $clog2(MAX_KERNEL * 255 + 1);
	localparam int WS_W = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
	localparam int AR_W = 2 * K_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD1 = 3'd1;
	localparam logic [2:0] ST_RD2 = 3'd2;
	localparam logic [2:0] ST_WIN = 3'd3;
	localparam logic [2:0] ST_DIV = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	// Configuration registers.
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic [K_W-1:0] kernel_width_q;
	logic [K_W-1:0] kernel_height_q;
	logic color_mode_q;

	logic [2:0] state_q;
	logic [COL_W-1:0] col_q, cur_col_q;
	logic [ROW_W-1:0] row_q, cur_row_q;
	logic [RING_W-1:0] ring_q;
	pixel_t px_q;
	logic [CS_W-1:0] newcs_q [3];
	logic [WS_W-1:0] win_q [3];
	logic frame_end_q;
	logic out_valid_q;
	mean_t out_q;

	// Memories: the last MAX_KERNEL rows of pixels and the per-column sums.
	pixel_t line_mem [LS_DEPTH];
	logic [3*CS_W-1:0] cs_mem [MAX_WIDTH];
	pixel_t ls_rd_q;
	logic [3*CS_W-1:0] cs_rd_q;

	logic [WE_W-1:0] w_eff;
	logic [HE_W-1:0] h_eff;
	logic kernel_ok;
	logic accept;
	logic advance;
	logic produce;
	logic [COL_W-1:0] acc_col;
	logic [ROW_W-1:0] acc_row;
	logic [RING_W-1:0] old_ring;
	logic [LA_W-1:0] wr_slot, rd_slot;
	logic [COL_W-1:0] left_col;
	logic [CS_W-1:0] pxc [3];
	logic [CS_W-1:0] leave [3];
	logic [CS_W-1:0] cs_new [3];
	logic [CS_W-1:0] cs_left [3];
	logic [WS_W-1:0] win_new [3];
	logic [AR_W-1:0] area;
	logic div_start;
	div_ctl_t div_ctl;
	logic [PIX_W-1:0] quo [3];
	logic out_load;

	// Effective geometry and kernel check.
	always_comb begin
		if (frame_width_q == '0) w_eff = WE_W'(1);
		else if (32'(frame_width_q) > MAX_WIDTH) w_eff = WE_W'(MAX_WIDTH);
		else w_eff = WE_W'(frame_width_q);
		if (frame_height_q == '0) h_eff = HE_W'(1);
		else if (32'(frame_height_q) > MAX_HEIGHT) h_eff = HE_W'(MAX_HEIGHT);
		else h_eff = HE_W'(frame_height_q);
		kernel_ok = kernel_width_q[0] && kernel_height_q[0]
			&& (32'(kernel_width_q) <= MAX_KERNEL) && (32'(kernel_height_q) <= MAX_KERNEL)
			&& (32'(kernel_width_q) <= 32'(w_eff)) && (32'(kernel_height_q) <= 32'(h_eff));
		acc_col = (32'(col_q) >= 32'(w_eff)) ? COL_W'(w_eff - 1'b1) : col_q;
		acc_row = (32'(row_q) >= 32'(h_eff)) ? ROW_W'(h_eff - 1'b1) : row_q;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;

	// Ring slot of the row leaving the window.
	always_comb begin
		if (32'(ring_q) >= 32'(kernel_height_q))
			old_ring = RING_W'(32'(ring_q) - 32'(kernel_height_q));
		else
			old_ring = RING_W'(32'(ring_q) + MAX_KERNEL - 32'(kernel_height_q));
		wr_slot = LA_W'(32'(ring_q) * MAX_WIDTH + 32'(cur_col_q));
		rd_slot = LA_W'(32'(old_ring) * MAX_WIDTH + 32'(cur_col_q));
		left_col = COL_W'(32'(cur_col_q) - 32'(kernel_width_q));
	end

	// Column-sum and window arithmetic.
	always_comb begin
		pxc[0] = CS_W'(px_q.pixel_c0);
		pxc[1] = CS_W'(px_q.pixel_c1);
		pxc[2] = CS_W'(px_q.pixel_c2);
		for (int i = 0; i < 3; i++) begin
			leave[i] = '0;
			if (32'(cur_row_q) >= 32'(kernel_height_q)) begin
				case (i)
					0: leave[i] = CS_W'(ls_rd_q.pixel_c0);
					1: leave[i] = CS_W'(ls_rd_q.pixel_c1);
					default: leave[i] = CS_W'(ls_rd_q.pixel_c2);
				endcase
			end
			if (cur_row_q == '0) cs_new[i] = pxc[i];
			else cs_new[i] = cs_rd_q[(2-i)*CS_W +: CS_W] + pxc[i] - leave[i];
			cs_left[i] = (32'(cur_col_q) >= 32'(kernel_width_q))
				? cs_rd_q[(2-i)*CS_W +: CS_W] : '0;
			win_new[i] = ((cur_col_q == '0) ? '0 : win_q[i]) + WS_W'(newcs_q[i])
				- WS_W'(cs_left[i]);
		end
	end

	assign produce = (32'(cur_row_q) + 1 >= 32'(kernel_height_q))
		&& (32'(cur_col_q) + 1 >= 32'(kernel_width_q));
	assign area = AR_W'(kernel_width_q) * AR_W'(kernel_height_q);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign advance = (accept && !kernel_ok) || ((state_q == ST_WIN) && !produce) || out_load;
	assign div_start = (state_q == ST_WIN) && produce;

	// Memory ports.
	always_ff @(posedge clk) begin
		if (state_q == ST_RD1) begin
			ls_rd_q <= line_mem[rd_slot];
			cs_rd_q <= cs_mem[cur_col_q];
		end else if (state_q == ST_RD2) begin
			cs_rd_q <= cs_mem[left_col];
		end
		if (state_q == ST_RD2) begin
			line_mem[wr_slot] <= px_q;
			cs_mem[cur_col_q] <= {cs_new[0], cs_new[1], cs_new[2]};
		end
	end

	// Item payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q.pixel_c0 <= in_item.pixel_c0;
			px_q.pixel_c1 <= color_mode_q ? in_item.pixel_c1 : '0;
			px_q.pixel_c2 <= color_mode_q ? in_item.pixel_c2 : '0;
			cur_col_q <= acc_col;
			cur_row_q <= acc_row;
		end
		if (state_q == ST_RD2) begin
			for (int i = 0; i < 3; i++) newcs_q[i] <= cs_new[i];
		end
		if (state_q == ST_WIN) begin
			frame_end_q <= (32'(cur_row_q) == 32'(h_eff) - 1)
				&& (32'(cur_col_q) == 32'(w_eff) - 1);
		end
		if (out_load) begin
			out_q.mean_c0 <= quo[0];
			out_q.mean_c1 <= quo[1];
			out_q.mean_c2 <= quo[2];
			out_q.frame_end <= frame_end_q;
		end
	end

	// Control state, positions, window sums and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FW_W'(320);
			frame_height_q <= FH_W'(240);
			kernel_width_q <= K_W'(3);
			kernel_height_q <= K_W'(3);
			color_mode_q <= 1'b0;
			state_q <= ST_IDLE;
			col_q <= '0;
			row_q <= '0;
			ring_q <= '0;
			for (int i = 0; i < 3; i++) win_q[i] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (out_load) out_valid_q <= 1'b1;

			case (state_q)
				ST_IDLE: if (accept && kernel_ok) state_q <= ST_RD1;
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: state_q <= ST_WIN;
				ST_WIN: begin
					for (int i = 0; i < 3; i++) win_q[i] <= win_new[i];
					state_q <= produce ? ST_DIV : ST_IDLE;
				end
				ST_DIV: if (div_ctl.done) state_q <= ST_OUT;
				ST_OUT: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase

			if (advance) begin
				if (32'(accept ? acc_col : cur_col_q) + 1 >= 32'(w_eff)) begin
					col_q <= '0;
					if (32'(accept ? acc_row : cur_row_q) + 1 >= 32'(h_eff)) begin
						row_q <= '0;
						ring_q <= '0;
					end else begin
						row_q <= (accept ? acc_row : cur_row_q) + 1'b1;
						ring_q <= (32'(ring_q) + 1 >= MAX_KERNEL) ? '0 : ring_q + 1'b1;
					end
				end else begin
					col_q <= (accept ? acc_col : cur_col_q) + 1'b1;
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH: frame_width_q <= cfg_data[FW_W-1:0];
					REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
					REG_KERNEL_WIDTH: kernel_width_q <= cfg_data[K_W-1:0];
					REG_KERNEL_HEIGHT: kernel_height_q <= cfg_data[K_W-1:0];
					REG_COLOR_MODE: color_mode_q <= cfg_data[0];
					default: ;
				endcase
				if (cfg_index inside {[REG_FRAME_WIDTH:REG_COLOR_MODE]}) begin
					col_q <= '0;
					row_q <= '0;
					ring_q <= '0;
					for (int i = 0; i < 3; i++) win_q[i] <= '0;
				end
			end
		end
	end

	bmf_div #(
		.NUM_W(WS_W),
		.DEN_W(AR_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num0(win_new[0]),
		.num1(win_new[1]),
		.num2(win_new[2]),
		.den(area),
		.ctl(div_ctl),
		.quo0(quo[0]),
		.quo1(quo[1]),
		.quo2(quo[2])
	);

	assign out_valid = out_valid_q;
	assign out_item = out_q;
endmodule
